FILE: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: shared package
// Word types, controller states and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int CFG_BITS = 7;
	localparam int AGE_BITS = 7;

	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;
	localparam logic [AGE_BITS-1:0] AGE_SAT = 7'd127;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic end_of_array;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] window_max;
		logic last_result;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic has_result;
		logic scan_busy;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/swm_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: controller
// Sequences one sample through load, update, optional rescan and, when a
// result is due, hand-off to the output register.
// ----------------------------------------------------------------------------
module swm_ctl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  swm_pkg::status_t status,
	output swm_pkg::cmd_t   cmd
);
	import swm_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (status.need_scan) begin
					state_next = ST_SCAN;
				end else if (status.has_result) begin
					state_next = ST_EMIT;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (!status.scan_busy) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Wait here until the output register can take the word.
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/swm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: datapath
// Window memory, fill and age tracking, the rescan read pipeline and the
// output register.
// ----------------------------------------------------------------------------
module swm_dp #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swm_pkg::in_word_t               in_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swm_pkg::CFG_BITS-1:0]    cfg_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output swm_pkg::out_word_t              out_word,
	input  swm_pkg::cmd_t                   cmd,
	output swm_pkg::status_t                status
);
	import swm_pkg::*;

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int PW = AW + 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_MAX - 1);

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

	logic [CFG_BITS-1:0] cfg_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic last_q;
	logic [AW-1:0] wp_q;
	logic [CFG_BITS-1:0] fc_q;
	logic [AGE_BITS-1:0] age_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic [CFG_BITS-1:0] scan_left_q;
	logic [AGE_BITS-1:0] scan_age_q;
	logic [AW-1:0] rd_ptr_q;
	logic first_q;
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic rd_valid_s1;
	logic [AGE_BITS-1:0] age_s1;
	logic first_s1;
	logic out_valid_q;
	out_word_t out_q;

	logic [CFG_BITS-1:0] w;
	logic [AGE_BITS-1:0] age_inc;
	logic [CFG_BITS-1:0] fc_inc;
	logic full;
	logic take_new;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] ptr_inc;
	logic [PW-1:0] start_sum;
	logic [AW-1:0] start_ptr;
	logic issue;
	logic rd_gt;

	// Effective window: zero acts as one, oversize clamps to the memory depth.
	always_comb begin
		if (cfg_q == '0) begin
			w = CFG_BITS'(1);
		end else if (32'(cfg_q) > 32'(WINDOW_MAX)) begin
			w = CFG_BITS'(WINDOW_MAX);
		end else begin
			w = cfg_q;
		end
	end

	assign age_inc = (age_q == AGE_SAT) ? age_q : age_q + AGE_BITS'(1);
	assign fc_inc = fc_q + CFG_BITS'(1);
	assign full = (fc_q >= w);
	assign status.need_scan = full ? (age_inc >= w) : (fc_inc == w);
	assign status.has_result = full || (fc_inc == w);
	assign take_new = full && !status.need_scan && (sample_q > max_q);

	assign wp_inc = (wp_q == LAST_SLOT) ? '0 : wp_q + AW'(1);
	assign ptr_inc = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);

	// Oldest slot of the window once the new sample is stored.
	assign start_sum = PW'(wp_inc) + PW'(WINDOW_MAX) - PW'(w);
	assign start_ptr = (start_sum >= PW'(WINDOW_MAX)) ?
		AW'(start_sum - PW'(WINDOW_MAX)) : AW'(start_sum);

	assign issue = cmd.scan_step && (scan_left_q != '0);
	assign rd_gt = (rdata_s1 > max_q);

	assign status.scan_busy = (scan_left_q != '0) || rd_valid_s1;
	assign status.out_free = !out_valid_q || !out_stall;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= WINDOW_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_word.sample;
			last_q <= in_word.end_of_array;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[wp_q] <= sample_q;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fc_q <= '0;
		end else if (cmd.update) begin
			wp_q <= wp_inc;
			fc_q <= last_q ? '0 : (full ? fc_q : fc_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
			max_q <= '0;
		end else if (cmd.update) begin
			if (take_new) begin
				max_q <= sample_q;
				age_q <= '0;
			end else begin
				age_q <= age_inc;
			end
		end else if (rd_valid_s1 && (first_s1 || rd_gt)) begin
			// Strictly greater keeps the oldest of equal maxima.
			max_q <= rdata_s1;
			age_q <= age_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_left_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cmd.update && status.need_scan) begin
				scan_left_q <= w;
			end else if (issue) begin
				scan_left_q <= scan_left_q - CFG_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && status.need_scan) begin
			scan_age_q <= AGE_BITS'(w - CFG_BITS'(1));
			rd_ptr_q <= start_ptr;
			first_q <= 1'b1;
		end else if (issue) begin
			scan_age_q <= scan_age_q - AGE_BITS'(1);
			rd_ptr_q <= ptr_inc;
			first_q <= 1'b0;
		end
		if (issue) begin
			age_s1 <= scan_age_q;
			first_s1 <= first_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.window_max <= max_q;
			out_q.last_result <= last_q;
		end
	end

	// A result never overwrites a word that is still waiting downstream.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result loaded into a full output register");

	// The maximum handed out always lies inside the current window.
	a_age_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (age_q < w))
		else $error("window maximum is older than the window");

	// Read data only returns for a read issued during a rescan.
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(cmd.scan_step))
		else $error("memory read data without a rescan step");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < 32'(WINDOW_MAX))
		else $error("write position beyond the window memory");

endmodule

FILE: hw/rtl/sliding_window_maximum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: top level
// Streams signed samples and returns the maximum of the last window_size
// samples of the current array once the window has filled.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample that needs no rescan passes from
// acceptance through load, update and, if a result is due, hand-off; one that
// does finish filling the window or lets the maximum age out of it rescans the
// stored window through the single read port of the window memory, one entry
// a cycle, before the hand-off. A new sample is accepted while the previous
// result still waits in the output register. No reset clearing pass is needed:
// the window memory is only read where the current array has written it.
module sliding_window_maximum #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  swm_pkg::in_word_t            in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output swm_pkg::out_word_t           out_word,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [swm_pkg::CFG_BITS-1:0] cfg_word
);
	import swm_pkg::*;

	cmd_t cmd;
	status_t status;

	swm_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	swm_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_word  (cfg_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: bench/sliding_window_maximum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: testbench
// Streams arrays of signed samples through the block under a series of window
// settings and checks every returned maximum against a cycle-free model of
// the window, or against the table for typed directed rows. The run opens with
// a directed table and goes on with random arrays, random gaps on both sides and one long output hold.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;
	import swm_pkg::*;

	localparam int DEPTH       = WINDOW_MAX_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 100;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7fff_ffff;

	typedef enum logic [1:0] {
		ROW_DATA,
		ROW_CFG
	} row_kind_t;

	// For a configuration row the sample column carries the window setting.
	typedef struct packed {
		row_kind_t                     kind;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          eoa;
		logic                          typed;
		logic signed [SAMPLE_BITS-1:0] exp_max;
		logic                          exp_last;
	} row_t;

	localparam int DIR_ROWS = 27;
	localparam row_t DIR_TBL [DIR_ROWS] = '{
		'{ROW_DATA, S_MIN,          1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, S_MAX,          1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd0,         1'b0, 1'b1, S_MAX,          1'b0},
		'{ROW_DATA, -32'sd1,        1'b0, 1'b1, S_MAX,          1'b0},
		'{ROW_DATA, 32'sd5,         1'b1, 1'b1, 32'sd5,         1'b1},
		'{ROW_DATA, 32'sd7,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd8,         1'b1, 1'b0, 32'sd0,         1'b0},
		'{ROW_CFG,  32'sd1,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, S_MIN,          1'b0, 1'b1, S_MIN,          1'b0},
		'{ROW_DATA, S_MAX,          1'b1, 1'b1, S_MAX,          1'b1},
		'{ROW_DATA, 32'shaaaa_aaaa, 1'b0, 1'b1, 32'shaaaa_aaaa, 1'b0},
		'{ROW_DATA, 32'sh5555_5555, 1'b1, 1'b1, 32'sh5555_5555, 1'b1},
		'{ROW_CFG,  32'sd0,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, -32'sd7,        1'b1, 1'b1, -32'sd7,        1'b1},
		'{ROW_CFG,  32'sd2,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd3,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd3,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd1,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_CFG,  32'sd4,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd2,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd9,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_CFG,  32'sd2,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd0,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, 32'sd0,         1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, -32'sd3,        1'b1, 1'b0, 32'sd0,         1'b0},
		'{ROW_CFG,  32'sd127,       1'b0, 1'b0, 32'sd0,         1'b0},
		'{ROW_DATA, S_MAX,          1'b1, 1'b0, 32'sd0,         1'b0}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_word_t            in_word;
	logic                out_valid;
	logic                out_stall;
	out_word_t           out_word;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_word;

	// Model of the window.
	logic signed [SAMPLE_BITS-1:0] win_mem [DEPTH];
	logic [5:0]                    wr_pos;
	logic [6:0]                    fill_cnt;
	logic [AGE_BITS-1:0]           mx_age;
	logic signed [SAMPLE_BITS-1:0] mx_val;
	logic [CFG_BITS-1:0]           win_size;

	out_word_t                     expected_max_q [$];
	logic signed [SAMPLE_BITS-1:0] prev_sample;
	int                            arr_left;
	int                            errors;
	int                            samples_in;
	int                            maxima_seen;
	int                            cfg_writes;
	int                            cycle_cnt;
	bit                            quiet;
	bit                            hold_req;

	sliding_window_maximum u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_word  (cfg_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] sample_at(int age);
		int idx;
		idx = (int'(wr_pos) + DEPTH - 1 - age) % DEPTH;
		return win_mem[idx];
	endfunction

	// Oldest to newest, so the oldest of equal maxima stays.
	function automatic void rescan_window(int w);
		int a;
		a = w - 1;
		mx_val = sample_at(a);
		mx_age = AGE_BITS'(a);
		while (a > 0) begin
			a--;
			if (sample_at(a) > mx_val) begin
				mx_val = sample_at(a);
				mx_age = AGE_BITS'(a);
			end
		end
	endfunction

	function automatic bit track_window_max(input in_word_t w, output out_word_t r);
		int ws;
		bit got;
		ws = int'(win_size);
		if (ws < 1)
			ws = 1;
		if (ws > DEPTH)
			ws = DEPTH;
		win_mem[wr_pos] = w.sample;
		wr_pos = wr_pos + 6'd1;
		if (mx_age < AGE_SAT)
			mx_age++;
		got = 1'b0;
		if (int'(fill_cnt) < ws) begin
			fill_cnt++;
			if (int'(fill_cnt) == ws) begin
				rescan_window(ws);
				got = 1'b1;
			end
		end else begin
			if (int'(mx_age) >= ws)
				rescan_window(ws);
			else if ($signed(w.sample) > mx_val) begin
				mx_val = w.sample;
				mx_age = '0;
			end
			got = 1'b1;
		end
		r.window_max = mx_val;
		r.last_result = w.end_of_array;
		if (w.end_of_array)
			fill_cnt = '0;
		return got;
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic eoa,
			input bit typed, input out_word_t typed_exp);
		in_word_t w;
		out_word_t r;
		bit got;
		w.sample = s;
		w.end_of_array = eoa;
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		got = track_window_max(w, r);
		if (typed)
			expected_max_q = {expected_max_q, typed_exp};
		else if (got)
			expected_max_q = {expected_max_q, r};
		samples_in++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// The block must be idle: drain every result, then give the last sample
	// time to leave the controller.
	task automatic set_window(input logic [CFG_BITS-1:0] v);
		in_valid <= 1'b0;
		while (expected_max_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_word <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_size = v;
		cfg_writes++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		logic signed [SAMPLE_BITS-1:0] s;
		case ($urandom_range(0, 9))
			0: s = S_MIN;
			1: s = S_MAX;
			2, 3, 4: s = $signed(SAMPLE_BITS'($urandom_range(0, 8))) - 32'sd4;
			5, 6: s = prev_sample - $signed(SAMPLE_BITS'($urandom_range(0, 3)));
			default: s = $signed($urandom);
		endcase
		prev_sample = s;
		return s;
	endfunction

	// An array left open at the end of a phase runs on under the next setting.
	task automatic run_phase(input logic [CFG_BITS-1:0] wcfg, input int n_items,
			input bit hold);
		int ws;
		int k;
		logic signed [SAMPLE_BITS-1:0] s;
		set_window(wcfg);
		ws = (wcfg == 0) ? 1 : ((int'(wcfg) > DEPTH) ? DEPTH : int'(wcfg));
		for (k = 0; k < n_items; k++) begin
			if (arr_left == 0) begin
				if ($urandom_range(0, 9) < 2)
					arr_left = (ws > 1) ? $urandom_range(1, ws - 1) : 1;
				else
					arr_left = ws + $urandom_range(0, (ws < 8) ? 12 : ws / 2);
			end
			if (hold && k == 10)
				hold_req = 1'b1;
			s = pick_sample();
			send_sample(s, arr_left == 1, 1'b0, '0);
			arr_left--;
		end
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			maxima_seen++;
			if (expected_max_q.size() == 0) begin
				$error("unexpected word: window_max %0d last_result %0b",
					$signed(out_word.window_max), out_word.last_result);
				errors++;
			end else begin
				want = expected_max_q.pop_front();
				if (out_word.window_max !== want.window_max) begin
					$error("window_max: expected %0d, actual %0d",
						$signed(want.window_max), $signed(out_word.window_max));
					errors++;
				end
				if (out_word.last_result !== want.last_result) begin
					$error("last_result: expected %0b, actual %0b",
						want.last_result, out_word.last_result);
					errors++;
				end
			end
		end
	end

	// Receiver: short random holds, and once a long one so the block backs up.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i;
		out_word_t typed_exp;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_word = '0;
		for (i = 0; i < DEPTH; i++)
			win_mem[i] = '0;
		wr_pos = '0;
		fill_cnt = '0;
		mx_age = '0;
		mx_val = '0;
		win_size = WINDOW_RESET;
		prev_sample = '0;
		arr_left = 0;
		errors = 0;
		samples_in = 0;
		maxima_seen = 0;
		cfg_writes = 0;
		quiet = 1'b0;
		hold_req = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TBL[i].kind == ROW_CFG)
				set_window(CFG_BITS'(DIR_TBL[i].sample));
			else begin
				typed_exp.window_max = DIR_TBL[i].exp_max;
				typed_exp.last_result = DIR_TBL[i].exp_last;
				send_sample(DIR_TBL[i].sample, DIR_TBL[i].eoa, DIR_TBL[i].typed,
					typed_exp);
			end
		end

		run_phase(7'd1, 50, 1'b0);
		run_phase(7'd64, 150, 1'b0);
		run_phase(7'd0, 50, 1'b0);
		run_phase(7'd5, 70, 1'b1);
		run_phase(7'd127, 100, 1'b0);
		run_phase(7'd2, 60, 1'b0);
		run_phase(CFG_BITS'($urandom_range(3, 12)), 60, 1'b0);
		run_phase(CFG_BITS'($urandom_range(13, 40)), 80, 1'b0);
		run_phase(WINDOW_RESET, 40, 1'b0);
		quiet = 1'b1;
		run_phase(CFG_BITS'($urandom_range(2, 8)), 60, 1'b0);

		in_valid <= 1'b0;
		while (expected_max_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d samples, %0d maxima, %0d window settings (1 to 64, 0, 127),",
			samples_in, maxima_seen, cfg_writes);
		$display("short arrays, mid-array resizes and a long output hold; %0d errors.",
			errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
